### hdl/rgb_to_spectrum_polynomial_defines.svh
// Assertion macros for the RGB-to-spectrum polynomial block.
// Used by the checker; depends on nothing else.
`ifndef RGB_TO_SPECTRUM_POLYNOMIAL_DEFINES_SVH
`define RGB_TO_SPECTRUM_POLYNOMIAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTSP_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rtsp assertion failed");

// Next-cycle implication, disabled during reset.
`define RTSP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rtsp assertion failed");

`endif

### hdl/rtsp_pkg.sv
// Shared types, widths, opcodes and monomial tables for the RGB-to-spectrum block.
// No dependencies.
`default_nettype none

package rtsp_pkg;

  localparam int NTERMS        = 36;
  localparam int COEF_W        = 32;
  localparam int CH_W          = 8;
  localparam int BAND_W        = 9;
  localparam int TERM_W        = 6;
  localparam int OUT_W         = 48;
  localparam int SUM_W         = 72;
  localparam int BANDS_DEFAULT = 512;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [31:0]              mono_t;
  typedef logic [2*CH_W-1:0]        sq_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Degree-2 products are kept in the order RR, RG, RB, GG, GB, BB.
  // Degree-3 terms: one square times one channel (0 = R, 1 = G, 2 = B).
  localparam logic [2:0] D3_SQ [10] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
                                        3'd2, 3'd3, 3'd3, 3'd4, 3'd5};
  localparam logic [1:0] D3_CH [10] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2,
                                        2'd2, 2'd1, 2'd2, 2'd2, 2'd2};
  // Degree-4 terms: product of two squares.
  localparam logic [2:0] D4_A [15] = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
                                       3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5};
  localparam logic [2:0] D4_B [15] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4,
                                       3'd5, 3'd5, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5};

endpackage

`default_nettype wire

### hdl/rgb_to_spectrum_polynomial.sv
// An evaluate transaction passes through the registered stages to the output; stall_i holds it there.
// Throughput: one transaction (load or evaluate) per cycle while stall_o is low; loads write one bank and end.
// Coefficients sit in 36 banks, one per term, so a band's whole set is read in the same access.
// Reset clears the stage valid bits only; the coefficient banks hold nothing defined
// until loaded.
// Depends on rtsp_pkg.
`default_nettype none

module rgb_to_spectrum_polynomial
  import rtsp_pkg::*;
#(
  parameter int BANDS = BANDS_DEFAULT
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output      logic                     stall_o,
  input  wire logic                     operation_i,
  input  wire logic [BAND_W-1:0]        band_i,
  input  wire logic [TERM_W-1:0]        term_i,
  input  wire logic signed [COEF_W-1:0] coefficient_i,
  input  wire logic [CH_W-1:0]          red_i,
  input  wire logic [CH_W-1:0]          green_i,
  input  wire logic [CH_W-1:0]          blue_i,
  input  wire logic                     last_pixel_i,
  output      logic                     valid_o,
  input  wire logic                     stall_i,
  output      logic signed [OUT_W-1:0]  spectral_value_o,
  output      logic [BAND_W-1:0]        band_out_o,
  output      logic                     last_out_o
);

  localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int NS = 7;

  logic [NS:1] v_q;
  logic [NS:1] adv;

  logic [BAND_W-1:0] band_q [1:NS];
  logic              last_q [1:NS];
  logic              oob_q  [1:NS];

  logic [AW-1:0] addr;
  logic          band_ok;
  logic          accept;

  // Each stage moves when it is empty or when the stage after it moves.
  always_comb begin
    adv[NS] = !v_q[NS] || !stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign stall_o = !adv[1];
  assign accept  = valid_i && !stall_o;
  assign addr    = AW'(band_i);
  assign band_ok = 32'(band_i) < BANDS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= valid_i && (operation_i == OP_EVAL);
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      band_q[1] <= band_i;
      last_q[1] <= last_pixel_i;
      oob_q[1]  <= !band_ok;
    end
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) begin
        band_q[k] <= band_q[k-1];
        last_q[k] <= last_q[k-1];
        oob_q[k]  <= oob_q[k-1];
      end
    end
  end

  // Stage 1: coefficient banks, read data registered.
  coef_t             c1_q [NTERMS];
  logic [CH_W-1:0]   ch1_q [3];

  for (genvar t = 0; t < NTERMS; t++) begin : g_bank
    coef_t bank_q [BANDS];
    logic  wr_en;

    assign wr_en = accept && (operation_i == OP_LOAD) && band_ok
                   && (term_i == TERM_W'(t));

    always_ff @(posedge clk_i) begin
      if (wr_en) begin
        bank_q[addr] <= coefficient_i;
      end
      if (adv[1]) begin
        c1_q[t] <= bank_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      ch1_q[0] <= red_i;
      ch1_q[1] <= green_i;
      ch1_q[2] <= blue_i;
    end
  end

  // Stage 2: degree-2 products.
  coef_t           c2_q  [NTERMS];
  logic [CH_W-1:0] ch2_q [3];
  sq_t             d2_q  [6];

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      c2_q  <= c1_q;
      ch2_q <= ch1_q;
      d2_q[0] <= ch1_q[0] * ch1_q[0];
      d2_q[1] <= ch1_q[0] * ch1_q[1];
      d2_q[2] <= ch1_q[0] * ch1_q[2];
      d2_q[3] <= ch1_q[1] * ch1_q[1];
      d2_q[4] <= ch1_q[1] * ch1_q[2];
      d2_q[5] <= ch1_q[2] * ch1_q[2];
    end
  end

  // Stage 3: all monomials, the two constant terms use one.
  coef_t c3_q [NTERMS];
  mono_t m3_d [NTERMS];
  mono_t m3_q [NTERMS];

  always_comb begin
    m3_d[0] = 32'd1;
    m3_d[1] = 32'd1;
    for (int c = 0; c < 3; c++) begin
      m3_d[2+c] = 32'(ch2_q[c]);
    end
    for (int i = 0; i < 6; i++) begin
      m3_d[5+i] = 32'(d2_q[i]);
    end
    for (int i = 0; i < 10; i++) begin
      m3_d[11+i] = mono_t'(d2_q[D3_SQ[i]]) * mono_t'(ch2_q[D3_CH[i]]);
    end
    for (int i = 0; i < 15; i++) begin
      m3_d[21+i] = mono_t'(d2_q[D4_A[i]]) * mono_t'(d2_q[D4_B[i]]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      c3_q <= c2_q;
      m3_q <= m3_d;
    end
  end

  // Stage 4: signed coefficient times unsigned monomial.
  sum_t p4_d [NTERMS];
  sum_t p4_q [NTERMS];

  always_comb begin
    logic signed [COEF_W+32:0] prod;
    for (int t = 0; t < NTERMS; t++) begin
      prod    = c3_q[t] * $signed({1'b0, m3_q[t]});
      p4_d[t] = SUM_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      p4_q <= p4_d;
    end
  end

  // Stages 5 and 6: registered adder tree, 36 to 9 to 3.
  sum_t s5_q [9];
  sum_t s6_q [3];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int i = 0; i < 9; i++) begin
        s5_q[i] <= p4_q[4*i] + p4_q[4*i+1] + p4_q[4*i+2] + p4_q[4*i+3];
      end
    end
    if (adv[6]) begin
      for (int i = 0; i < 3; i++) begin
        s6_q[i] <= s5_q[3*i] + s5_q[3*i+1] + s5_q[3*i+2];
      end
    end
  end

  // Stage 7: final sum, saturation to the output width (zero for an out-of-range band), output register.
  sum_t                   total;
  logic signed [OUT_W-1:0] sat_d;
  logic signed [OUT_W-1:0] value_q;

  always_comb begin
    total = s6_q[0] + s6_q[1] + s6_q[2];
    if (oob_q[NS-1]) begin
      sat_d = '0;
    end else if ((&total[SUM_W-1:OUT_W-1]) || !(|total[SUM_W-1:OUT_W-1])) begin
      sat_d = total[OUT_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat_d = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_d = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      value_q <= sat_d;
    end
  end

  assign valid_o          = v_q[NS];
  assign spectral_value_o = value_q;
  assign band_out_o       = band_q[NS];
  assign last_out_o       = last_q[NS];

endmodule

`default_nettype wire

### hdl/rtsp_checker.sv
// Port-level checks for the RGB-to-spectrum block, bound to its top level.
// Depends on rtsp_pkg and rgb_to_spectrum_polynomial_defines.svh.
`default_nettype none
`include "rgb_to_spectrum_polynomial_defines.svh"

module rtsp_checker
  import rtsp_pkg::*;
#(
  parameter int BANDS = BANDS_DEFAULT
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     valid_i,
  input wire logic                     stall_o,
  input wire logic                     operation_i,
  input wire logic [BAND_W-1:0]        band_i,
  input wire logic                     last_pixel_i,
  input wire logic                     valid_o,
  input wire logic                     stall_i,
  input wire logic signed [OUT_W-1:0]  spectral_value_o,
  input wire logic [BAND_W-1:0]        band_out_o,
  input wire logic                     last_out_o
);

  // A held result keeps its valid and its payload.
  `RTSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i,
    valid_o && $stable(spectral_value_o) && $stable(band_out_o) && $stable(last_out_o))

  // The input side only stalls behind a stalled, full output register.
  `RTSP_ASSERT_SAME(a_stall_cause, clk_i, rst_ni, stall_o, valid_o && stall_i)

  // A band outside the store gives a zero value.
  `RTSP_ASSERT_SAME(a_oob_zero, clk_i, rst_ni, valid_o && (32'(band_out_o) >= BANDS),
    spectral_value_o == '0)

  // With no output stall, an evaluate comes out on valid_o with its band and last flag.
  `RTSP_ASSERT_NEXT(a_latency, clk_i, rst_ni,
    (valid_i && !stall_o && operation_i == OP_EVAL && !stall_i)
      ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i,
    valid_o && band_out_o == $past(band_i, 7) && last_out_o == $past(last_pixel_i, 7))

endmodule

bind rgb_to_spectrum_polynomial rtsp_checker #(.BANDS(BANDS)) u_rtsp_checker (.*);

`default_nettype wire
